>>> sv/cppc_pkg.sv
// Shared types and constants of the convex polygon plane clipper.
`timescale 1ns / 1ps
package cppc_pkg;

	// One vertex, signed Q16.16 per axis
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} vtx_t;

	// Result status codes
	localparam logic [1:0] ST_VERTEX   = 2'd0;
	localparam logic [1:0] ST_CULLED   = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	// Configuration register indexes
	localparam logic [2:0] REG_PLANE_COUNT = 3'd0;
	localparam logic [2:0] REG_PLANE_0     = 3'd1;
	localparam logic [2:0] REG_NEAR_EPS    = 3'd7;

	localparam int MIN_KEPT = 3;
	localparam int T_BITS   = 24;
	localparam int B_LIMIT  = 38;
	localparam int DIST_W   = 50;  // signed plane distance in Q.30
	localparam int DEN_W    = 51;  // distance difference
	localparam int REM_W    = 40;  // divider remainder
	localparam int MA_W     = 33;  // multiplier operand a
	localparam int MB_W     = 26;  // multiplier operand b
	localparam int MP_W     = MA_W + MB_W;

	// Sequencer states
	typedef enum logic [9:0] {
		S_IDLE  = 10'b00_0000_0001,
		S_FETCH = 10'b00_0000_0010,
		S_LATCH = 10'b00_0000_0100,
		S_DIST  = 10'b00_0000_1000,
		S_NEXT  = 10'b00_0001_0000,
		S_EDGE  = 10'b00_0010_0000,
		S_NORM  = 10'b00_0100_0000,
		S_DIV   = 10'b00_1000_0000,
		S_LERP  = 10'b01_0000_0000,
		S_ADV   = 10'b10_0000_0000
	} state_t;

	localparam state_t S_OUT_MARK = S_IDLE;

endpackage

>>> sv/convex_polygon_plane_clipper_top.sv
// Top level of the convex polygon plane clipper: vertex stores, sequencer, shared datapath.
//
//  channel   signals                           transfer
//  vertex    start busy vx vy vz poly_end      start & !busy
//  result    done ox oy oz status out_last     done (one cycle, no stall)
//  config    cfg_we cfg_index cfg_data         cfg_we
//
// Vertices load at one per cycle. After poly_end the block is busy while it clips with
// one shared multiplier: each plane walks the vertices through the fetch, latch, distance,
// edge, advance and next states, and a crossing adds a normalize step per shift plus one,
// 25 divider steps and 5 lerp steps. A culled or overflow status shows the cycle after it
// is found; otherwise output streams one vertex per cycle, the first done registered
// through rd_s1 and done_q after the last plane ends, and busy drops with the last done.
// Reset clears the sequencer and its working registers; the vertex stores are not cleared.
// The result side cannot stall: each result shows for one cycle with done.
`timescale 1ns / 1ps
module convex_polygon_plane_clipper_top
	import cppc_pkg::*;
#(
	parameter int MAX_VERTS  = 32,
	parameter int MAX_PLANES = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] vx,
	input  logic signed [31:0] vy,
	input  logic signed [31:0] vz,
	input  logic               poly_end,
	output logic               done,
	output logic signed [31:0] ox,
	output logic signed [31:0] oy,
	output logic signed [31:0] oz,
	output logic [1:0]         status,
	output logic               out_last,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data
);

	localparam int AW = $clog2(MAX_VERTS);
	localparam int CW = AW + 1;
	localparam logic [CW-1:0] MAXV = CW'(MAX_VERTS);

	// Configuration registers
	logic [2:0]  plane_count_q;
	logic [63:0] planes_q [MAX_PLANES];
	logic [15:0] near_eps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_count_q <= '0;
			near_eps_q    <= 16'd16;
			for (int i = 0; i < MAX_PLANES; i++) planes_q[i] <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_PLANE_COUNT) plane_count_q <= cfg_data[2:0];
			if (cfg_index == REG_NEAR_EPS) near_eps_q <= cfg_data[15:0];
			for (int i = 0; i < MAX_PLANES; i++)
				if (cfg_index == REG_PLANE_0 + 3'(i)) planes_q[i] <= cfg_data;
		end
	end

	logic [2:0] pc_sat;
	assign pc_sat = (plane_count_q > 3'(MAX_PLANES)) ? 3'(MAX_PLANES) : plane_count_q;

	// Control and datapath registers
	state_t state_q;
	logic [CW-1:0] cnt_q, n_q, m_q, j_q, idx_q;
	logic          ovf_q, bank_q, first_q;
	logic [2:0]    plane_q;
	logic [4:0]    sub_q;
	logic          rd_s1, last_s1;
	vtx_t          vk_q, pj_q, v0_q, crs_q;
	logic signed [DIST_W-1:0] acc_q, dk_q, dj_q, d0_q;
	logic signed [MP_W-1:0]   prod_q;
	logic [DEN_W-1:0]         a_q, b_q;
	logic [REM_W-1:0]         rem_q;
	logic [T_BITS:0]          q_q, t_q;
	logic          done_q, last_q;
	logic [1:0]    status_q;
	vtx_t          out_q;

	// Plane select
	logic [63:0] pl_sel;
	always_comb begin
		pl_sel = '0;
		for (int i = 0; i < MAX_PLANES; i++)
			if (plane_q == 3'(i)) pl_sel = planes_q[i];
	end

	// Vertex stores, one write and one registered read each
	vtx_t mem_a [MAX_VERTS];
	vtx_t mem_b [MAX_VERTS];
	vtx_t rd_a_q, rd_b_q, rd_sel;
	logic          wr_en, wr_bank;
	logic [AW-1:0] wr_addr;
	vtx_t          wr_data;

	always_ff @(posedge clk) begin
		if (wr_en && !wr_bank) mem_a[wr_addr] <= wr_data;
		if (wr_en && wr_bank) mem_b[wr_addr] <= wr_data;
		rd_a_q <= mem_a[idx_q[AW-1:0]];
		rd_b_q <= mem_b[idx_q[AW-1:0]];
	end
	assign rd_sel = bank_q ? rd_b_q : rd_a_q;

	logic accept;
	assign accept = start && !busy;

	// Close test between current edge ends
	logic signed [32:0] dxs, dys, dzs;
	logic [32:0] adx, ady, adz;
	logic close;
	always_comb begin
		dxs = 33'(vk_q.x) - 33'(pj_q.x);
		dys = 33'(vk_q.y) - 33'(pj_q.y);
		dzs = 33'(vk_q.z) - 33'(pj_q.z);
		adx = dxs[32] ? 33'(-dxs) : 33'(dxs);
		ady = dys[32] ? 33'(-dys) : 33'(dys);
		adz = dzs[32] ? 33'(-dzs) : 33'(dzs);
		close = (adx < 33'(near_eps_q)) && (ady < 33'(near_eps_q)) && (adz < 33'(near_eps_q));
	end

	logic in_j, in_k;
	assign in_j = dj_q < 0;
	assign in_k = dk_q < 0;

	logic signed [DEN_W-1:0] den;
	assign den = DEN_W'(dk_q) - DEN_W'(dj_q);

	// Shared multiplier operands
	logic signed [MA_W-1:0] mul_a;
	logic signed [MB_W-1:0] mul_b;
	logic signed [MP_W-1:0] mul_p;
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == S_DIST) begin
			case (sub_q[1:0])
				2'd0: begin mul_a = MA_W'(vk_q.x); mul_b = MB_W'($signed(pl_sel[15:0])); end
				2'd1: begin mul_a = MA_W'(vk_q.y); mul_b = MB_W'($signed(pl_sel[31:16])); end
				2'd2: begin mul_a = MA_W'(vk_q.z); mul_b = MB_W'($signed(pl_sel[47:32])); end
				default: ;
			endcase
		end else begin
			mul_b = $signed({1'b0, t_q});
			case (sub_q[1:0])
				2'd0: mul_a = dxs;
				2'd1: mul_a = dys;
				2'd2: mul_a = dzs;
				default: ;
			endcase
		end
	end
	assign mul_p = mul_a * mul_b;

	logic signed [DIST_W-1:0] dist_sum;
	assign dist_sum = acc_q + DIST_W'(prod_q);

	// Lerp axis from the registered product
	logic signed [MP_W-1:0] off_full;
	logic signed [31:0] lerp_v;
	always_comb begin
		off_full = prod_q >>> T_BITS;
		case (sub_q[1:0])
			2'd1: lerp_v = pj_q.x + off_full[31:0];
			2'd2: lerp_v = pj_q.y + off_full[31:0];
			default: lerp_v = pj_q.z + off_full[31:0];
		endcase
	end

	// Divider step
	logic [REM_W-1:0] r2;
	logic ge;
	logic [T_BITS:0] q_next;
	always_comb begin
		r2 = (sub_q == 5'd0) ? rem_q : {rem_q[REM_W-2:0], 1'b0};
		ge = r2 >= REM_W'(b_q[B_LIMIT-1:0]);
		q_next = {q_q[T_BITS-1:0], ge};
	end

	// Store write port
	always_comb begin
		wr_en   = 1'b0;
		wr_bank = ~bank_q;
		wr_addr = m_q[AW-1:0];
		wr_data = pj_q;
		if (state_q == S_IDLE) begin
			wr_en   = accept && (cnt_q < MAXV);
			wr_bank = 1'b0;
			wr_addr = cnt_q[AW-1:0];
			wr_data = '{x: vx, y: vy, z: vz};
		end else if (state_q == S_EDGE) begin
			wr_en = !close && in_j && (m_q < MAXV);
		end else if (state_q == S_LERP) begin
			wr_en   = (sub_q == 5'd4) && (m_q < MAXV);
			wr_data = crs_q;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			ovf_q    <= 1'b0;
			n_q      <= '0;
			m_q      <= '0;
			j_q      <= '0;
			idx_q    <= '0;
			bank_q   <= 1'b0;
			first_q  <= 1'b0;
			plane_q  <= '0;
			sub_q    <= '0;
			rd_s1    <= 1'b0;
			last_s1  <= 1'b0;
			done_q   <= 1'b0;
			status_q <= ST_VERTEX;
			vk_q     <= '0;
			pj_q     <= '0;
			v0_q     <= '0;
			crs_q    <= '0;
			acc_q    <= '0;
			dk_q     <= '0;
			dj_q     <= '0;
			d0_q     <= '0;
			prod_q   <= '0;
			a_q      <= '0;
			b_q      <= '0;
			rem_q    <= '0;
			q_q      <= '0;
			t_q      <= '0;
		end else begin
			done_q <= 1'b0;
			rd_s1  <= 1'b0;
			if (rd_s1) done_q <= 1'b1;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (cnt_q < MAXV) cnt_q <= cnt_q + 1'b1;
						else ovf_q <= 1'b1;
						if (poly_end) begin
							cnt_q  <= '0;
							ovf_q  <= 1'b0;
							bank_q <= 1'b0;
							plane_q <= '0;
							idx_q  <= '0;
							n_q    <= (cnt_q < MAXV) ? cnt_q + 1'b1 : cnt_q;
							if (ovf_q || cnt_q >= MAXV) begin
								done_q   <= 1'b1;
								status_q <= ST_OVERFLOW;
							end else if (pc_sat == 3'd0) begin
								state_q <= S_ADV;
								first_q <= 1'b1;
							end else begin
								first_q <= 1'b1;
								m_q     <= '0;
								state_q <= S_FETCH;
							end
						end
					end
				end
				S_FETCH: state_q <= S_LATCH;
				S_LATCH: begin
					vk_q    <= rd_sel;
					sub_q   <= '0;
					state_q <= S_DIST;
				end
				S_DIST: begin
					prod_q <= mul_p;
					sub_q  <= sub_q + 1'b1;
					if (sub_q == 5'd0) acc_q <= DIST_W'($signed(pl_sel[63:48])) <<< 30;
					else acc_q <= dist_sum;
					if (sub_q == 5'd3) begin
						dk_q <= dist_sum;
						if (first_q) begin
							first_q <= 1'b0;
							v0_q <= vk_q;
							d0_q <= dist_sum;
							pj_q <= vk_q;
							dj_q <= dist_sum;
							j_q  <= '0;
							state_q <= S_NEXT;
						end else begin
							state_q <= S_EDGE;
						end
					end
				end
				S_NEXT: begin
					if (j_q + 1'b1 < n_q) begin
						idx_q   <= j_q + 1'b1;
						state_q <= S_FETCH;
					end else begin
						vk_q    <= v0_q;
						dk_q    <= d0_q;
						state_q <= S_EDGE;
					end
				end
				S_EDGE: begin
					state_q <= S_ADV;
					if (!close) begin
						if (in_j) begin
							if (m_q >= MAXV) begin
								done_q   <= 1'b1;
								status_q <= ST_OVERFLOW;
								state_q  <= S_IDLE;
							end else begin
								m_q <= m_q + 1'b1;
							end
						end
						if (in_j != in_k && den != 0 && !(in_j && m_q >= MAXV)) begin
							a_q <= dj_q[DIST_W-1] ? DEN_W'(-dj_q) : DEN_W'(dj_q);
							b_q <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
							state_q <= S_NORM;
						end
					end
				end
				S_NORM: begin
					if (|b_q[DEN_W-1:B_LIMIT]) begin
						a_q <= a_q >> 1;
						b_q <= b_q >> 1;
					end else begin
						rem_q   <= a_q[REM_W-1:0];
						q_q     <= '0;
						sub_q   <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= ge ? r2 - REM_W'(b_q[B_LIMIT-1:0]) : r2;
					q_q   <= q_next;
					sub_q <= sub_q + 1'b1;
					if (sub_q == 5'(T_BITS)) begin
						t_q <= (q_next > (T_BITS+1)'(1 << T_BITS)) ?
							(T_BITS+1)'(1 << T_BITS) : q_next;
						sub_q   <= '0;
						state_q <= S_LERP;
					end
				end
				S_LERP: begin
					prod_q <= mul_p;
					sub_q  <= sub_q + 1'b1;
					case (sub_q[2:0])
						3'd1: crs_q.x <= lerp_v;
						3'd2: crs_q.y <= lerp_v;
						3'd3: crs_q.z <= lerp_v;
						default: ;
					endcase
					if (sub_q == 5'd4) begin
						if (m_q >= MAXV) begin
							done_q   <= 1'b1;
							status_q <= ST_OVERFLOW;
							state_q  <= S_IDLE;
						end else begin
							m_q     <= m_q + 1'b1;
							state_q <= S_ADV;
						end
					end
				end
				S_ADV: begin
					if (first_q) begin
						// output stream from the source store
						rd_s1   <= 1'b1;
						last_s1 <= (idx_q + 1'b1 == n_q);
						idx_q   <= idx_q + 1'b1;
						if (idx_q + 1'b1 == n_q) begin
							first_q <= 1'b0;
							state_q <= S_IDLE;
						end
					end else begin
						pj_q <= vk_q;
						dj_q <= dk_q;
						j_q  <= j_q + 1'b1;
						if (j_q + 1'b1 == n_q) begin
							if (m_q < CW'(MIN_KEPT)) begin
								done_q   <= 1'b1;
								status_q <= ST_CULLED;
								state_q  <= S_IDLE;
							end else begin
								bank_q  <= ~bank_q;
								n_q     <= m_q;
								m_q     <= '0;
								idx_q   <= '0;
								first_q <= 1'b1;
								plane_q <= plane_q + 1'b1;
								state_q <= (plane_q + 1'b1 == pc_sat) ? S_ADV : S_FETCH;
							end
						end else begin
							state_q <= S_NEXT;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (rd_s1) status_q <= ST_VERTEX;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (rd_s1) begin
			out_q  <= rd_sel;
			last_q <= last_s1;
		end else if (state_q != S_IDLE || accept) begin
			out_q  <= '0;
			last_q <= 1'b1;
		end
	end

	assign busy     = (state_q != S_OUT_MARK) || rd_s1;
	assign done     = done_q;
	assign ox       = out_q.x;
	assign oy       = out_q.y;
	assign oz       = out_q.z;
	assign status   = status_q;
	assign out_last = last_q;

endmodule

>>> sv/cppc_checker.sv
// Port-level checks for the convex polygon plane clipper, bound to the top level.
`timescale 1ns / 1ps
module cppc_checker
	import cppc_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               poly_end,
	input logic               done,
	input logic signed [31:0] ox,
	input logic signed [31:0] oy,
	input logic signed [31:0] oz,
	input logic [1:0]         status,
	input logic               out_last
);

	// a vertex transfer without poly_end gives no result next cycle
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !poly_end) |=> !done)
		else $error("result after a non-final vertex");

	// idle and no start: nothing comes out
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy && !start) |=> !done)
		else $error("result while idle");

	// status results are single and final
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_VERTEX) |-> (out_last && ox == 0 && oy == 0 && oz == 0))
		else $error("status result not final or not zeroed");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ST_VERTEX || status == ST_CULLED || status == ST_OVERFLOW))
		else $error("bad status code");

endmodule

bind convex_polygon_plane_clipper_top cppc_checker u_cppc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.poly_end (poly_end),
	.done     (done),
	.ox       (ox),
	.oy       (oy),
	.oz       (oz),
	.status   (status),
	.out_last (out_last)
);
